// ----- sv/bfc_pkg.sv -----
`default_nettype none

package bfc_pkg;

   // request kinds
   localparam logic [2:0] KIND_WRITE = 3'd0;
   localparam logic [2:0] KIND_READ  = 3'd1;
   localparam logic [2:0] KIND_PEEK  = 3'd2;
   localparam logic [2:0] KIND_FLUSH = 3'd3;
   localparam logic [2:0] KIND_CLEAR = 3'd4;

   // result event codes
   localparam logic [1:0] EV_STATUS = 2'd0;
   localparam logic [1:0] EV_START  = 2'd1;
   localparam logic [1:0] EV_DATA   = 2'd2;
   localparam logic [1:0] EV_STOP   = 2'd3;

   // configuration register indexes
   localparam logic CSR_DRAIN_EN = 1'b0;
   localparam logic CSR_DEV_ADDR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DATA,
      ST_STOP,
      ST_FINISH
   } state_type;

   // datapath commands, one per cycle
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_EXEC,
      CMD_LATCH,
      CMD_START,
      CMD_BYTE,
      CMD_STOP,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic need_drain;
      logic fill_zero;
      logic fill_one;
      logic chunk_last;
   } stat_type;

endpackage

`default_nettype wire

// ----- sv/byte_fifo_with_chunked_i2c_drain.sv -----
// Requests that need no drain: status word in the cycle after accept, one request per cycle.
// A drain runs one event per cycle from the controller: with N bytes in T = ceil(N/CHUNK)
// transactions, busy stays high until the status word, which comes last.
// Results are shown for one cycle each under rsp_strobe; the receiver cannot stall.
// Synchronous reset clears positions, fill count, configuration and the controller;
// stored bytes are not cleared.
`default_nettype none

module byte_fifo_with_chunked_i2c_drain #(
   parameter int DEPTH = 32,
   parameter int CHUNK = 30
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output      logic       busy,
   input  wire logic [2:0] req_kind,
   input  wire logic [7:0] req_data_in,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [6:0] csr_wdata,
   output      logic       rsp_strobe,
   output      logic [1:0] rsp_event_res,
   output      logic [7:0] rsp_value,
   output      logic       rsp_accepted,
   output      logic       rsp_byte_valid,
   output      logic [5:0] rsp_level,
   output      logic       rsp_last
);

   bfc_pkg::cmd_type  cmd;
   bfc_pkg::stat_type stat;

   bfc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   bfc_dp #(
      .DEPTH (DEPTH),
      .CHUNK (CHUNK)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_kind       (req_kind),
      .req_data_in    (req_data_in),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .stat           (stat),
      .rsp_strobe     (rsp_strobe),
      .rsp_event_res  (rsp_event_res),
      .rsp_value      (rsp_value),
      .rsp_accepted   (rsp_accepted),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_level      (rsp_level),
      .rsp_last       (rsp_last)
   );

   // only the status word closes a request
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> rsp_event_res == bfc_pkg::EV_STATUS)
      else $error("last word is not a status word");

   // a request without drain answers in the next cycle
   a_quick_status: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !stat.need_drain |=> rsp_strobe && rsp_last)
      else $error("missing status after plain request");

   // a transaction start is followed by a byte or a stop
   a_start_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_event_res == bfc_pkg::EV_START |=>
      rsp_strobe && (rsp_event_res == bfc_pkg::EV_DATA ||
                     rsp_event_res == bfc_pkg::EV_STOP))
      else $error("start event not followed by data or stop");

   // busy drops together with the status word of a drained request
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe && rsp_last)
      else $error("drain ended without status word");

endmodule

`default_nettype wire

// ----- sv/bfc_ctrl.sv -----
`default_nettype none

module bfc_ctrl (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic start,
   input  wire bfc_pkg::stat_type stat,
   output      bfc_pkg::cmd_type  cmd,
   output      logic              busy
);

   bfc_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfc_pkg::ST_IDLE: begin
            if (start && stat.need_drain) state_in = bfc_pkg::ST_START;
         end
         bfc_pkg::ST_START: begin
            state_in = bfc_pkg::ST_DATA;
         end
         bfc_pkg::ST_DATA: begin
            // close the transaction on the last byte or a full chunk
            if (stat.fill_one || stat.chunk_last) state_in = bfc_pkg::ST_STOP;
         end
         bfc_pkg::ST_STOP: begin
            state_in = stat.fill_zero ? bfc_pkg::ST_FINISH : bfc_pkg::ST_START;
         end
         bfc_pkg::ST_FINISH: begin
            state_in = bfc_pkg::ST_IDLE;
         end
         default: begin
            state_in = bfc_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd  = bfc_pkg::CMD_NONE;
      busy = 1'b1;
      unique case (state_ff)
         bfc_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) cmd = stat.need_drain ? bfc_pkg::CMD_LATCH : bfc_pkg::CMD_EXEC;
         end
         bfc_pkg::ST_START:  cmd = bfc_pkg::CMD_START;
         bfc_pkg::ST_DATA:   cmd = bfc_pkg::CMD_BYTE;
         bfc_pkg::ST_STOP:   cmd = bfc_pkg::CMD_STOP;
         bfc_pkg::ST_FINISH: cmd = bfc_pkg::CMD_FINISH;
         default:            cmd = bfc_pkg::CMD_NONE;
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/bfc_dp.sv -----
`default_nettype none

module bfc_dp #(
   parameter int DEPTH = 32,
   parameter int CHUNK = 30
) (
   input  wire                 logic       clock,
   input  wire                 logic       reset,
   input  wire bfc_pkg::cmd_type           cmd,
   input  wire                 logic [2:0] req_kind,
   input  wire                 logic [7:0] req_data_in,
   input  wire                 logic       csr_we,
   input  wire                 logic       csr_index,
   input  wire                 logic [6:0] csr_wdata,
   output      bfc_pkg::stat_type          stat,
   output      logic                       rsp_strobe,
   output      logic [1:0]                 rsp_event_res,
   output      logic [7:0]                 rsp_value,
   output      logic                       rsp_accepted,
   output      logic                       rsp_byte_valid,
   output      logic [5:0]                 rsp_level,
   output      logic                       rsp_last
);

   localparam int PW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int CKW = $clog2(CHUNK + 1);

   // configuration
   logic       drain_en_ff;
   logic [6:0] dev_addr_ff;

   // ring state
   logic [7:0]    store_ff [DEPTH];
   logic          store_we;
   logic [7:0]    store_in;
   logic [PW-1:0] wr_pos_ff, wr_pos_in, wr_next;
   logic [PW-1:0] rd_pos_ff, rd_pos_in, rd_next;
   logic [CW-1:0] fill_ff, fill_in;
   logic [7:0]    rd_data;

   // drain bookkeeping and the request held across a drain
   logic [CKW-1:0] chunk_ff, chunk_in;
   logic [2:0]     pend_kind_ff, pend_kind_in;
   logic [7:0]     pend_data_ff, pend_data_in;
   logic [2:0]     exec_kind;
   logic [7:0]     exec_data;

   // result word
   logic       strobe_ff, strobe_in;
   logic [1:0] event_ff, event_in;
   logic [7:0] value_ff, value_in;
   logic       acc_ff, acc_in;
   logic       valid_ff, valid_in;
   logic [5:0] level_ff;
   logic       last_ff, last_in;

   assign rd_data = store_ff[rd_pos_ff];
   assign wr_next = (wr_pos_ff == PW'(DEPTH - 1)) ? '0 : wr_pos_ff + PW'(1);
   assign rd_next = (rd_pos_ff == PW'(DEPTH - 1)) ? '0 : rd_pos_ff + PW'(1);

   // status toward the controller
   always_comb begin
      stat.need_drain = drain_en_ff &&
         ((req_kind == bfc_pkg::KIND_WRITE && fill_ff > CW'(DEPTH / 2)) ||
          (req_kind == bfc_pkg::KIND_FLUSH && fill_ff != '0));
      stat.fill_zero  = (fill_ff == '0);
      stat.fill_one   = (fill_ff == CW'(1));
      stat.chunk_last = (chunk_ff == CKW'(CHUNK - 1));
   end

   // a finishing request comes from the held copy, otherwise from the ports
   assign exec_kind = (cmd == bfc_pkg::CMD_FINISH) ? pend_kind_ff : req_kind;
   assign exec_data = (cmd == bfc_pkg::CMD_FINISH) ? pend_data_ff : req_data_in;

   // command decode
   always_comb begin
      store_we     = 1'b0;
      store_in     = exec_data;
      wr_pos_in    = wr_pos_ff;
      rd_pos_in    = rd_pos_ff;
      fill_in      = fill_ff;
      chunk_in     = chunk_ff;
      pend_kind_in = pend_kind_ff;
      pend_data_in = pend_data_ff;
      strobe_in    = 1'b0;
      event_in     = bfc_pkg::EV_STATUS;
      value_in     = 8'd0;
      acc_in       = 1'b0;
      valid_in     = 1'b0;
      last_in      = 1'b0;
      unique case (cmd)
         bfc_pkg::CMD_NONE: begin
         end
         bfc_pkg::CMD_LATCH: begin
            pend_kind_in = req_kind;
            pend_data_in = req_data_in;
         end
         bfc_pkg::CMD_START: begin
            strobe_in = 1'b1;
            event_in  = bfc_pkg::EV_START;
            value_in  = {1'b0, dev_addr_ff};
            chunk_in  = '0;
         end
         bfc_pkg::CMD_BYTE: begin
            strobe_in = 1'b1;
            event_in  = bfc_pkg::EV_DATA;
            value_in  = rd_data;
            rd_pos_in = rd_next;
            fill_in   = fill_ff - CW'(1);
            chunk_in  = chunk_ff + CKW'(1);
         end
         bfc_pkg::CMD_STOP: begin
            strobe_in = 1'b1;
            event_in  = bfc_pkg::EV_STOP;
         end
         bfc_pkg::CMD_EXEC, bfc_pkg::CMD_FINISH: begin
            strobe_in = 1'b1;
            last_in   = 1'b1;
            unique case (exec_kind)
               bfc_pkg::KIND_WRITE: begin
                  if (fill_ff != CW'(DEPTH)) begin
                     store_we  = 1'b1;
                     wr_pos_in = wr_next;
                     fill_in   = fill_ff + CW'(1);
                     acc_in    = 1'b1;
                  end
               end
               bfc_pkg::KIND_READ: begin
                  if (fill_ff != '0) begin
                     value_in  = rd_data;
                     valid_in  = 1'b1;
                     rd_pos_in = rd_next;
                     fill_in   = fill_ff - CW'(1);
                  end
               end
               bfc_pkg::KIND_PEEK: begin
                  if (fill_ff != '0) begin
                     value_in = rd_data;
                     valid_in = 1'b1;
                  end
               end
               bfc_pkg::KIND_CLEAR: begin
                  wr_pos_in = '0;
                  rd_pos_in = '0;
                  fill_in   = '0;
               end
               // flush has already drained when drain is enabled; flush and unused kinds only report
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // byte store, no reset
   always_ff @(posedge clock) begin
      if (store_we) store_ff[wr_pos_ff] <= store_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         drain_en_ff <= 1'b0;
         dev_addr_ff <= 7'd0;
         wr_pos_ff   <= '0;
         rd_pos_ff   <= '0;
         fill_ff     <= '0;
         chunk_ff    <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               bfc_pkg::CSR_DRAIN_EN: drain_en_ff <= csr_wdata[0];
               bfc_pkg::CSR_DEV_ADDR: dev_addr_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         wr_pos_ff <= wr_pos_in;
         rd_pos_ff <= rd_pos_in;
         fill_ff   <= fill_in;
         chunk_ff  <= chunk_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      pend_data_ff <= pend_data_in;
      event_ff     <= event_in;
      value_ff     <= value_in;
      acc_ff       <= acc_in;
      valid_ff     <= valid_in;
      level_ff     <= 6'(fill_in);
      last_ff      <= last_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_event_res  = event_ff;
   assign rsp_value      = value_ff;
   assign rsp_accepted   = acc_ff;
   assign rsp_byte_valid = valid_ff;
   assign rsp_level      = level_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int DEPTH = 32;
   localparam int CHUNK = 30;
   localparam int CYCLE_LIMIT = 200000;
   localparam int N_DIR = 26;

   // kind codes the block does not define
   localparam logic [2:0] KIND_RSVD5 = 3'd5;
   localparam logic [2:0] KIND_RSVD6 = 3'd6;
   localparam logic [2:0] KIND_RSVD7 = 3'd7;

   typedef struct packed {
      logic [1:0] ev;
      logic [7:0] value;
      logic       accepted;
      logic       byte_valid;
      logic [5:0] level;
      logic       last;
   } fifo_word_type;

   // directed row: either a register write or a request with an optional status
   typedef struct packed {
      logic       is_csr;
      logic       csr_idx;
      logic [2:0] kind;
      logic [7:0] data;
      logic       typed;
      logic [7:0] value;
      logic       acc;
      logic       vld;
      logic [5:0] level;
   } dir_row_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [2:0] req_kind = bfc_pkg::KIND_READ;
   logic [7:0] req_data_in = 8'h00;
   logic       csr_we = 1'b0;
   logic       csr_index = bfc_pkg::CSR_DRAIN_EN;
   logic [6:0] csr_wdata = 7'h00;
   logic       rsp_strobe;
   logic [1:0] rsp_event_res;
   logic [7:0] rsp_value;
   logic       rsp_accepted;
   logic       rsp_byte_valid;
   logic [5:0] rsp_level;
   logic       rsp_last;

   byte_fifo_with_chunked_i2c_drain #(.DEPTH(DEPTH), .CHUNK(CHUNK)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_data_in    (req_data_in),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_event_res  (rsp_event_res),
      .rsp_value      (rsp_value),
      .rsp_accepted   (rsp_accepted),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_level      (rsp_level),
      .rsp_last       (rsp_last)
   );

   // model copy of the ring and the registers
   logic [7:0] ring_bytes [DEPTH];
   int         ring_wr;
   int         ring_rd;
   int         ring_fill;
   logic       drain_en;
   logic [6:0] dev_addr;

   fifo_word_type expected_words [$];
   fifo_word_type got_word;
   int            idle_pct;
   int            n_fail;
   int            n_items;
   int            n_checked;
   int            n_drains;
   int            n_transactions;
   int            n_dropped;
   int            cycles;

   dir_row_type dir_rows [0:N_DIR-1] = '{
      // empty after reset, drain off, address zero
      '{1'b0, 1'b0, bfc_pkg::KIND_READ,  8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, bfc_pkg::KIND_PEEK,  8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, bfc_pkg::KIND_FLUSH, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, KIND_RSVD5,          8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, KIND_RSVD6,          8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, KIND_RSVD7,          8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, bfc_pkg::KIND_WRITE, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 6'd1},
      '{1'b0, 1'b0, bfc_pkg::KIND_WRITE, 8'hFF, 1'b1, 8'h00, 1'b1, 1'b0, 6'd2},
      '{1'b0, 1'b0, bfc_pkg::KIND_WRITE, 8'hA5, 1'b1, 8'h00, 1'b1, 1'b0, 6'd3},
      '{1'b0, 1'b0, bfc_pkg::KIND_PEEK,  8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 6'd3},
      '{1'b0, 1'b0, bfc_pkg::KIND_READ,  8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 6'd2},
      '{1'b0, 1'b0, bfc_pkg::KIND_READ,  8'h00, 1'b1, 8'hFF, 1'b0, 1'b1, 6'd1},
      '{1'b0, 1'b0, bfc_pkg::KIND_CLEAR, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, bfc_pkg::KIND_READ,  8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, bfc_pkg::KIND_WRITE, 8'h55, 1'b1, 8'h00, 1'b1, 1'b0, 6'd1},
      '{1'b0, 1'b0, bfc_pkg::KIND_WRITE, 8'hAA, 1'b0, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, bfc_pkg::KIND_WRITE, 8'h01, 1'b0, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, bfc_pkg::KIND_WRITE, 8'h80, 1'b0, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, bfc_pkg::KIND_PEEK,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, bfc_pkg::KIND_FLUSH, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, bfc_pkg::KIND_READ,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 6'd0},
      // drain on: a flush now sends start, the bytes left, stop
      '{1'b1, bfc_pkg::CSR_DRAIN_EN, bfc_pkg::KIND_WRITE, 8'h01,
        1'b0, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b1, bfc_pkg::CSR_DEV_ADDR, bfc_pkg::KIND_WRITE, 8'h13,
        1'b0, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, bfc_pkg::KIND_WRITE, 8'h3C, 1'b0, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, bfc_pkg::KIND_FLUSH, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 6'd0},
      '{1'b0, 1'b0, bfc_pkg::KIND_CLEAR, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 6'd0}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------- ring model ----------------

   task automatic expect_word(input logic [1:0] ev, input logic [7:0] val,
                              input logic acc, input logic vld, input logic lst);
      fifo_word_type w;
      w = '{ev, val, acc, vld, ring_fill[5:0], lst};
      expected_words.push_back(w);
   endtask

   function automatic logic [7:0] pop_ring();
      logic [7:0] b;
      b = ring_bytes[ring_rd];
      ring_rd = (ring_rd == DEPTH - 1) ? 0 : ring_rd + 1;
      ring_fill--;
      return b;
   endfunction

   // empty the ring as transactions of up to CHUNK bytes
   task automatic drain_ring();
      int i;
      if (drain_en && ring_fill > 0) begin
         n_drains++;
         while (ring_fill > 0) begin
            n_transactions++;
            expect_word(bfc_pkg::EV_START, {1'b0, dev_addr}, 1'b0, 1'b0, 1'b0);
            for (i = 0; i < CHUNK && ring_fill > 0; i++)
               expect_word(bfc_pkg::EV_DATA, pop_ring(), 1'b0, 1'b0, 1'b0);
            expect_word(bfc_pkg::EV_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
         end
      end
   endtask

   task automatic apply_request(input logic [2:0] kind, input logic [7:0] data);
      logic [7:0] val;
      logic       acc;
      logic       vld;
      val = 8'h00;
      acc = 1'b0;
      vld = 1'b0;
      case (kind)
         bfc_pkg::KIND_WRITE: begin
            if (ring_fill > DEPTH / 2)
               drain_ring();
            if (ring_fill < DEPTH) begin
               ring_bytes[ring_wr] = data;
               ring_wr = (ring_wr == DEPTH - 1) ? 0 : ring_wr + 1;
               ring_fill++;
               acc = 1'b1;
            end else begin
               n_dropped++;
            end
         end
         bfc_pkg::KIND_READ: begin
            if (ring_fill > 0) begin
               val = pop_ring();
               vld = 1'b1;
            end
         end
         bfc_pkg::KIND_PEEK: begin
            if (ring_fill > 0) begin
               val = ring_bytes[ring_rd];
               vld = 1'b1;
            end
         end
         bfc_pkg::KIND_FLUSH: drain_ring();
         bfc_pkg::KIND_CLEAR: begin
            ring_wr = 0;
            ring_rd = 0;
            ring_fill = 0;
         end
         default: ;
      endcase
      expect_word(bfc_pkg::EV_STATUS, val, acc, vld, 1'b1);
   endtask

   // ---------------- request side ----------------

   // present one request, hold it until taken, then predict its words
   task automatic send_item(input logic [2:0] kind, input logic [7:0] data);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_data_in <= data;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      apply_request(kind, data);
      n_items++;
   endtask

   // register write once every expected word has come out
   task automatic write_csr(input logic idx, input logic [6:0] val);
      start <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == bfc_pkg::CSR_DRAIN_EN)
         drain_en = val[0];
      else
         dev_addr = val;
   endtask

   // random mix of requests, mostly writes, then an optional run of writes
   task automatic run_phase(input int n_mix, input int fill_burst);
      int         r;
      logic [2:0] kind;
      repeat (n_mix) begin
         r = $urandom_range(99);
         if (r < 4) begin
            repeat ($urandom_range(16, 4))
               send_item(bfc_pkg::KIND_WRITE, 8'($urandom_range(255)));
         end else begin
            r = $urandom_range(99);
            if (r < 55)
               kind = bfc_pkg::KIND_WRITE;
            else if (r < 68)
               kind = bfc_pkg::KIND_READ;
            else if (r < 78)
               kind = bfc_pkg::KIND_PEEK;
            else if (r < 88)
               kind = bfc_pkg::KIND_FLUSH;
            else if (r < 94)
               kind = bfc_pkg::KIND_CLEAR;
            else
               kind = 3'($urandom_range(KIND_RSVD7, KIND_RSVD5));
            send_item(kind, 8'($urandom_range(255)));
         end
      end
      repeat (fill_burst)
         send_item(bfc_pkg::KIND_WRITE, 8'($urandom_range(255)));
   endtask

   // ---------------- result side ----------------

   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
         n_fail++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            $display("%0t: word with none expected, event %0d value %0h level %0d",
                     $time, rsp_event_res, rsp_value, rsp_level);
            n_fail++;
         end else begin
            got_word = expected_words.pop_front();
            check_field("event_res", 8'(got_word.ev), 8'(rsp_event_res));
            check_field("value", got_word.value, rsp_value);
            check_field("accepted", 8'(got_word.accepted), 8'(rsp_accepted));
            check_field("byte_valid", 8'(got_word.byte_valid), 8'(rsp_byte_valid));
            check_field("level", 8'(got_word.level), 8'(rsp_level));
            check_field("last", 8'(got_word.last), 8'(rsp_last));
            n_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d words outstanding", $time, expected_words.size());
         $display("status: fail");
         $finish;
      end
   end

   // ---------------- main sequence ----------------

   initial begin
      dir_row_type   row;
      fifo_word_type w;
      ring_wr = 0;
      ring_rd = 0;
      ring_fill = 0;
      drain_en = 1'b0;
      dev_addr = 7'h00;
      n_fail = 0;
      n_items = 0;
      n_checked = 0;
      n_drains = 0;
      n_transactions = 0;
      n_dropped = 0;
      cycles = 0;
      idle_pct = 19;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < N_DIR; i++) begin
         row = dir_rows[i];
         if (row.is_csr) begin
            write_csr(row.csr_idx, row.data[6:0]);
         end else begin
            send_item(row.kind, row.data);
            if (row.typed) begin
               w = expected_words.pop_back();
               w = '{bfc_pkg::EV_STATUS, row.value, row.acc, row.vld, row.level, 1'b1};
               expected_words.push_back(w);
            end
         end
      end

      // drain off: fill past full so writes get dropped
      write_csr(bfc_pkg::CSR_DRAIN_EN, 7'h00);
      write_csr(bfc_pkg::CSR_DEV_ADDR, 7'h00);
      run_phase(20, 33);

      // drain on with a full ring: two transactions, then store
      write_csr(bfc_pkg::CSR_DRAIN_EN, 7'h01);
      write_csr(bfc_pkg::CSR_DEV_ADDR, 7'h7F);
      send_item(bfc_pkg::KIND_WRITE, 8'($urandom_range(255)));
      run_phase(20, 0);

      idle_pct = 57;
      write_csr(bfc_pkg::CSR_DEV_ADDR, 7'h2A);
      run_phase(20, 0);

      write_csr(bfc_pkg::CSR_DRAIN_EN, 7'h00);
      write_csr(bfc_pkg::CSR_DEV_ADDR, 7'h55);
      run_phase(20, 33);

      // full ring flushed in one request
      idle_pct = 0;
      write_csr(bfc_pkg::CSR_DRAIN_EN, 7'h01);
      write_csr(bfc_pkg::CSR_DEV_ADDR, 7'h00);
      send_item(bfc_pkg::KIND_FLUSH, 8'($urandom_range(255)));
      run_phase(20, 0);

      write_csr(bfc_pkg::CSR_DRAIN_EN, 7'h00);
      write_csr(bfc_pkg::CSR_DEV_ADDR, 7'($urandom_range(127)));
      run_phase(20, 0);

      // let everything come out
      start <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (expected_words.size() != 0) begin
         $display("%0t: %0d expected words never came", $time, expected_words.size());
         n_fail++;
      end

      $display("Ran %0d requests and checked %0d result words.", n_items, n_checked);
      $display("Saw %0d drains over %0d transactions and %0d dropped writes; %0d errors.",
               n_drains, n_transactions, n_dropped, n_fail);
      if (n_fail == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
